// ----- rtl/core/dsc_pkg.sv -----
// Shared types and constants for the door sequence controller.
// No dependencies; used by dsc_timer, dsc_seq and the core top level.
package dsc_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int LIMIT_BITS   = 16;
  localparam int CMP_BITS     = (COUNTER_BITS > LIMIT_BITS) ? COUNTER_BITS : LIMIT_BITS;
  localparam int POS_BITS     = 10;
  localparam int VOLT_BITS    = 8;
  localparam int PROD_BITS    = VOLT_BITS + 4;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [POS_BITS-1:0]     HI_MARK = POS_BITS'(950);
  localparam logic [POS_BITS-1:0]     LO_MARK = POS_BITS'(50);

  // request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_OPEN  = 2'd1;
  localparam logic [1:0] REQ_CLOSE = 2'd2;

  // door status codes
  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_MOVING = 2'd1;
  localparam logic [1:0] ST_OPEN   = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_NOMINAL = 2'd0;
  localparam logic [1:0] REG_STEPS   = 2'd1;
  localparam logic [1:0] REG_WARN    = 2'd2;
  localparam logic [1:0] REG_BLINK   = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [VOLT_BITS-1:0] supply_voltage;
    logic [POS_BITS-1:0]  step_position;
    logic [POS_BITS-1:0]  rail_position;
    logic [POS_BITS-1:0]  door_position;
  } item_t;

  typedef struct packed {
    logic       step_drive;
    logic       rail_drive;
    logic       door_drive;
    logic       warning_lamp;
    logic [1:0] door_status;
  } result_t;

  typedef struct packed {
    logic [VOLT_BITS-1:0]  nominal_voltage;
    logic                  steps_fitted;
    logic [LIMIT_BITS-1:0] warning_ticks;
    logic [LIMIT_BITS-1:0] blink_half_ticks;
  } cfg_t;

  // timer control for one word
  typedef struct packed {
    logic tick;          // advance the count
    logic start;         // restart from zero, running
    logic stop;          // clear running and count (wins over start)
    logic stop_on_fire;  // firing ends the run
  } timer_ctl_t;

endpackage

// ----- rtl/core/door_sequence_controller_core.sv -----
// Door sequence controller core. Each input word is a tick (supply voltage and
// step, rail and door positions in permille) or an open or close command, and
// yields exactly one output word with the three drive commands, the warning lamp
// and the door status. A word enters an input register, is evaluated in one pass
// of compare and counter logic while it is held there, and lands in an output
// register through the single rules stage: throughput one word per clock while
// output words are read. While a finished word waits on the output side, one
// more word is taken into the input register; input then stalls until the
// output word is read. Configuration writes are accepted every cycle (cfg_ready
// is tied high) and must only be issued while no word is in flight. Supply below
// 90 percent of nominal on a tick clears the request, drives, lamp and timers.
module door_sequence_controller_core (
  input  logic        clk,
  input  logic        rst,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [7:0] supply_voltage, [17:8] step_position,
                                     // [27:18] rail_position, [37:28] door_position
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] step_drive, [1] rail_drive, [2] door_drive,
                                     // [3] warning_lamp, [5:4] door_status
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  dsc_pkg::cfg_t    cfg;
  dsc_pkg::item_t   in_item;
  dsc_pkg::result_t result, out_word;
  logic             in_valid;
  logic             advance;
  logic             blink_active;

  // ---- config registers ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nominal_voltage  <= dsc_pkg::VOLT_BITS'(110);
      cfg.steps_fitted     <= 1'b1;
      cfg.warning_ticks    <= dsc_pkg::LIMIT_BITS'(100);
      cfg.blink_half_ticks <= dsc_pkg::LIMIT_BITS'(25);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dsc_pkg::REG_NOMINAL: cfg.nominal_voltage  <= cfg_data[dsc_pkg::VOLT_BITS-1:0];
        dsc_pkg::REG_STEPS:   cfg.steps_fitted     <= cfg_data[0];
        dsc_pkg::REG_WARN:    cfg.warning_ticks    <= cfg_data[dsc_pkg::LIMIT_BITS-1:0];
        dsc_pkg::REG_BLINK:   cfg.blink_half_ticks <= cfg_data[dsc_pkg::LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ---- input register ----
  // word leaves the input register for the output register when the output slot is free or being drained
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.req_type       <= s_axis_tuser;
      in_item.supply_voltage <= s_axis_tdata[7:0];
      in_item.step_position  <= s_axis_tdata[17:8];
      in_item.rail_position  <= s_axis_tdata[27:18];
      in_item.door_position  <= s_axis_tdata[37:28];
    end
  end

  // ---- rules stage: state updates only when the word advances ----
  dsc_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .update       (advance),
    .item         (in_item),
    .cfg          (cfg),
    .result       (result),
    .blink_active (blink_active)
  );

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word <= result;
    end
  end

  assign m_axis_tdata = {2'b00, out_word.door_status, out_word.warning_lamp,
                         out_word.door_drive, out_word.rail_drive, out_word.step_drive};

  // ---- checks ----
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_word.door_status != 2'd3))
    else $error("door_status carries an unused code");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("evaluated word did not reach the output register");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid)
    else $error("input stalled with an empty input register");

  a_lamp_needs_blink: assert property (@(posedge clk) disable iff (rst)
    (advance && result.warning_lamp) |=> blink_active)
    else $error("warning lamp lit without a running blink timer");

endmodule

// ----- rtl/core/dsc_timer.sv -----
// Saturating tick timer: running bit and count, fires at its limit.
// Depends on dsc_pkg.
module dsc_timer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  dsc_pkg::timer_ctl_t            ctl,
  input  logic [dsc_pkg::LIMIT_BITS-1:0] limit,
  output logic                           running,
  output logic                           fire
);

  logic [dsc_pkg::COUNTER_BITS-1:0] count;
  logic [dsc_pkg::COUNTER_BITS-1:0] count_inc;
  logic [dsc_pkg::COUNTER_BITS-1:0] count_next;
  logic                             running_next;

  assign count_inc = (count < dsc_pkg::CNT_MAX) ? count + 1'b1 : count;

  assign fire = ctl.tick && running &&
                ((dsc_pkg::CMP_BITS'(count_inc) >= dsc_pkg::CMP_BITS'(limit)) ||
                 (count_inc == dsc_pkg::CNT_MAX));

  always_comb begin
    running_next = running;
    count_next   = count;
    if (ctl.stop) begin
      running_next = 1'b0;
      count_next   = '0;
    end else if (ctl.start) begin
      running_next = 1'b1;
      count_next   = '0;
    end else if (ctl.tick && running) begin
      running_next = !(fire && ctl.stop_on_fire);
      count_next   = fire ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      count   <= '0;
    end else if (update) begin
      running <= running_next;
      count   <= count_next;
    end
  end

endmodule

// ----- rtl/core/dsc_seq.sv -----
// Sequencing rules: request latch, drive commands, lamp, both timers.
// Depends on dsc_pkg and dsc_timer.
module dsc_seq (
  input  logic             clk,
  input  logic             rst,
  input  logic             update,
  input  dsc_pkg::item_t   item,
  input  dsc_pkg::cfg_t    cfg,
  output dsc_pkg::result_t result,
  output logic             blink_active
);

  logic open_requested, open_requested_next;
  logic step_cmd, step_cmd_next;
  logic rail_cmd, rail_cmd_next;
  logic door_cmd, door_cmd_next;
  logic lamp_on, lamp_on_next;
  logic [dsc_pkg::POS_BITS-1:0] last_step, last_step_next;
  logic [dsc_pkg::POS_BITS-1:0] last_rail, last_rail_next;
  logic [dsc_pkg::POS_BITS-1:0] last_door, last_door_next;

  logic is_tick, power_ok, run_rules;
  logic [dsc_pkg::PROD_BITS-1:0] volts_x10, nominal_x9;
  logic sp_hi, rp_hi, rp_lo, dp_hi, dp_lo;
  logic blink_running, blink_fire, delay_running, delay_fire, blink_mid;
  dsc_pkg::timer_ctl_t blink_ctl, delay_ctl;

  assign is_tick    = (item.req_type == dsc_pkg::REQ_TICK);
  assign volts_x10  = dsc_pkg::PROD_BITS'(item.supply_voltage) * dsc_pkg::PROD_BITS'(10);
  assign nominal_x9 = dsc_pkg::PROD_BITS'(cfg.nominal_voltage) * dsc_pkg::PROD_BITS'(9);
  assign power_ok   = !(volts_x10 < nominal_x9);
  assign run_rules  = is_tick && power_ok;

  assign sp_hi = item.step_position > dsc_pkg::HI_MARK;
  assign rp_hi = item.rail_position > dsc_pkg::HI_MARK;
  assign rp_lo = item.rail_position < dsc_pkg::LO_MARK;
  assign dp_hi = item.door_position > dsc_pkg::HI_MARK;
  assign dp_lo = item.door_position < dsc_pkg::LO_MARK;

  // blink running as seen by the close rules, after any start this tick
  assign blink_mid = blink_running || !dp_lo;

  always_comb begin
    blink_ctl.tick         = run_rules;
    blink_ctl.stop_on_fire = 1'b0;
    delay_ctl.tick         = run_rules;
    delay_ctl.stop_on_fire = 1'b1;
    blink_ctl.start        = 1'b0;
    blink_ctl.stop         = is_tick && !power_ok;
    delay_ctl.start        = 1'b0;
    delay_ctl.stop         = is_tick && !power_ok;
    if (run_rules) begin
      if (open_requested) begin
        delay_ctl.stop  = 1'b1;
        blink_ctl.stop  = dp_hi;
        blink_ctl.start = !dp_hi && !blink_running;
      end else begin
        blink_ctl.start = !dp_lo && !blink_running;
        delay_ctl.start = !dp_lo && !blink_running;
        blink_ctl.stop  = blink_mid && rp_lo;
      end
    end
  end

  dsc_timer u_blink (
    .clk     (clk),
    .rst     (rst),
    .update  (update),
    .ctl     (blink_ctl),
    .limit   (cfg.blink_half_ticks),
    .running (blink_running),
    .fire    (blink_fire)
  );

  dsc_timer u_delay (
    .clk     (clk),
    .rst     (rst),
    .update  (update),
    .ctl     (delay_ctl),
    .limit   (cfg.warning_ticks),
    .running (delay_running),
    .fire    (delay_fire)
  );

  always_comb begin
    open_requested_next = open_requested;
    step_cmd_next       = step_cmd;
    rail_cmd_next       = rail_cmd;
    door_cmd_next       = door_cmd;
    lamp_on_next        = lamp_on;
    last_step_next      = last_step;
    last_rail_next      = last_rail;
    last_door_next      = last_door;
    unique case (item.req_type)
      dsc_pkg::REQ_TICK: begin
        last_step_next = item.step_position;
        last_rail_next = item.rail_position;
        last_door_next = item.door_position;
        if (!power_ok) begin
          open_requested_next = 1'b0;
          step_cmd_next       = 1'b0;
          rail_cmd_next       = 1'b0;
          door_cmd_next       = 1'b0;
          lamp_on_next        = 1'b0;
        end else if (open_requested) begin
          lamp_on_next  = (lamp_on ^ blink_fire) && !dp_hi;
          step_cmd_next = cfg.steps_fitted;
          rail_cmd_next = cfg.steps_fitted ? sp_hi : 1'b1;
          door_cmd_next = rp_hi;
        end else begin
          lamp_on_next  = (lamp_on ^ blink_fire) && !(blink_mid && rp_lo);
          step_cmd_next = cfg.steps_fitted && !rp_lo;
          door_cmd_next = door_cmd && !delay_fire && !dp_lo;
          rail_cmd_next = blink_mid ? !dp_lo : (rail_cmd && !dp_lo);
        end
      end
      dsc_pkg::REQ_OPEN:  open_requested_next = 1'b1;
      dsc_pkg::REQ_CLOSE: open_requested_next = 1'b0;
      default: ;
    endcase
  end

  always_comb begin
    result.step_drive   = step_cmd_next;
    result.rail_drive   = rail_cmd_next;
    result.door_drive   = door_cmd_next;
    result.warning_lamp = lamp_on_next;
    if (last_step_next < dsc_pkg::LO_MARK && last_rail_next < dsc_pkg::LO_MARK &&
        last_door_next < dsc_pkg::LO_MARK) begin
      result.door_status = dsc_pkg::ST_CLOSED;
    end else if (open_requested_next && last_door_next > dsc_pkg::HI_MARK) begin
      result.door_status = dsc_pkg::ST_OPEN;
    end else begin
      result.door_status = dsc_pkg::ST_MOVING;
    end
  end

  assign blink_active = blink_running;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_requested <= 1'b0;
      step_cmd       <= 1'b0;
      rail_cmd       <= 1'b0;
      door_cmd       <= 1'b0;
      lamp_on        <= 1'b0;
      last_step      <= '0;
      last_rail      <= '0;
      last_door      <= '0;
    end else if (update) begin
      open_requested <= open_requested_next;
      step_cmd       <= step_cmd_next;
      rail_cmd       <= rail_cmd_next;
      door_cmd       <= door_cmd_next;
      lamp_on        <= lamp_on_next;
      last_step      <= last_step_next;
      last_rail      <= last_rail_next;
      last_door      <= last_door_next;
    end
  end

  // lamp is only lit while the blink timer runs (checked at top level)
  logic unused_delay;
  assign unused_delay = delay_running;

endmodule

// ----- test/tb_top.sv -----
// Self-checking bench for door_sequence_controller_core: predicts every output word
// and checks it as it comes out. Needs dsc_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_top;

  // request code that the block must ignore
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Tracks the controller state word by word and keeps the output words it owes.
  class door_cmd_tracker;
    dsc_pkg::cfg_t    cfg;
    bit               open_req, step_cmd, rail_cmd, door_cmd, lamp;
    bit               blink_run, delay_run;
    logic [15:0]      blink_cnt, delay_cnt;
    logic [9:0]       last_sp, last_rp, last_dp;
    dsc_pkg::result_t pending_outputs[$];
    int               mismatches;

    function new();
      cfg.nominal_voltage  = 8'd110;
      cfg.steps_fitted     = 1'b1;
      cfg.warning_ticks    = 16'd100;
      cfg.blink_half_ticks = 16'd25;
      open_req = 0; step_cmd = 0; rail_cmd = 0; door_cmd = 0; lamp = 0;
      blink_run = 0; delay_run = 0; blink_cnt = '0; delay_cnt = '0;
      last_sp = '0; last_rp = '0; last_dp = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] d);
      case (idx)
        dsc_pkg::REG_NOMINAL: cfg.nominal_voltage  = d[7:0];
        dsc_pkg::REG_STEPS:   cfg.steps_fitted     = d[0];
        dsc_pkg::REG_WARN:    cfg.warning_ticks    = d;
        dsc_pkg::REG_BLINK:   cfg.blink_half_ticks = d;
        default: ;
      endcase
    endfunction

    // count saturates; fires on reaching the limit or saturation, then wraps to 0
    function bit timer_step(inout bit run, inout logic [15:0] cnt, input logic [15:0] limit);
      if (!run) return 0;
      if (cnt != dsc_pkg::CNT_MAX) cnt = cnt + 16'd1;
      if (cnt >= limit || cnt == dsc_pkg::CNT_MAX) begin
        cnt = '0;
        return 1;
      end
      return 0;
    endfunction

    function void sequence_rules(logic [9:0] sp, logic [9:0] rp, logic [9:0] dp);
      if (open_req) begin
        delay_run = 0; delay_cnt = '0;
        if (dp > dsc_pkg::HI_MARK) begin
          door_cmd = 1; rail_cmd = 1;
          blink_run = 0; blink_cnt = '0; lamp = 0;
        end else if (!blink_run) begin
          blink_run = 1; blink_cnt = '0;
        end
        if (cfg.steps_fitted) begin
          step_cmd = 1;
          rail_cmd = sp > dsc_pkg::HI_MARK;
        end else begin
          step_cmd = 0;
          rail_cmd = 1;
        end
        door_cmd = rp > dsc_pkg::HI_MARK;
      end else begin
        if (dp < dsc_pkg::LO_MARK) begin
          door_cmd = 0; rail_cmd = 0;
        end else if (!blink_run) begin
          // closing an open leaf: warning delay and lamp both start
          delay_run = 1; delay_cnt = '0;
          blink_run = 1; blink_cnt = '0;
        end
        if (blink_run) begin
          rail_cmd = !(dp < dsc_pkg::LO_MARK);
          if (rp < dsc_pkg::LO_MARK) begin
            blink_run = 0; blink_cnt = '0; lamp = 0;
          end
        end
        step_cmd = cfg.steps_fitted ? !(rp < dsc_pkg::LO_MARK) : 1'b0;
      end
    endfunction

    function void tick(dsc_pkg::item_t w);
      last_sp = w.step_position;
      last_rp = w.rail_position;
      last_dp = w.door_position;
      if (int'(w.supply_voltage) * 10 < int'(cfg.nominal_voltage) * 9) begin
        // brown-out: everything back to rest
        open_req = 0; step_cmd = 0; rail_cmd = 0; door_cmd = 0; lamp = 0;
        blink_run = 0; blink_cnt = '0; delay_run = 0; delay_cnt = '0;
        return;
      end
      if (timer_step(blink_run, blink_cnt, cfg.blink_half_ticks)) lamp = !lamp;
      if (timer_step(delay_run, delay_cnt, cfg.warning_ticks)) begin
        delay_run = 0; delay_cnt = '0; door_cmd = 0;
      end
      sequence_rules(w.step_position, w.rail_position, w.door_position);
    endfunction

    // called for every accepted input word
    function void take_word(dsc_pkg::item_t w);
      dsc_pkg::result_t r;
      case (w.req_type)
        dsc_pkg::REQ_TICK:  tick(w);
        dsc_pkg::REQ_OPEN:  open_req = 1;
        dsc_pkg::REQ_CLOSE: open_req = 0;
        default: ;
      endcase
      if (last_sp < dsc_pkg::LO_MARK && last_rp < dsc_pkg::LO_MARK &&
          last_dp < dsc_pkg::LO_MARK)
        r.door_status = dsc_pkg::ST_CLOSED;
      else if (open_req && last_dp > dsc_pkg::HI_MARK)
        r.door_status = dsc_pkg::ST_OPEN;
      else
        r.door_status = dsc_pkg::ST_MOVING;
      r.step_drive   = step_cmd;
      r.rail_drive   = rail_cmd;
      r.door_drive   = door_cmd;
      r.warning_lamp = lamp;
      pending_outputs.push_back(r);
    endfunction

    function void check_field(string name, int exp_v, int got_v);
      if (exp_v != got_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      end
    endfunction

    // called for every accepted output word
    function void match_output(logic [7:0] data);
      dsc_pkg::result_t e;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: output word 0x%02h with none expected", $time, data);
        return;
      end
      e = pending_outputs.pop_front();
      check_field("step_drive",   e.step_drive,   data[0]);
      check_field("rail_drive",   e.rail_drive,   data[1]);
      check_field("door_drive",   e.door_drive,   data[2]);
      check_field("warning_lamp", e.warning_lamp, data[3]);
      check_field("door_status",  e.door_status,  data[5:4]);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  door_cmd_tracker tracker = new();
  bit calm = 0;                       // set for the final stretch: no idling anywhere
  int step_pos = 0, rail_pos = 0, door_pos = 0;  // crude door mechanics

  door_sequence_controller_core u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // output side: runs of ready broken by random stalls
  initial begin
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) tracker.match_output(m_axis_tdata);
  end

  function automatic dsc_pkg::item_t make_word(logic [1:0] kind, logic [7:0] v,
                                               logic [9:0] sp, logic [9:0] rp,
                                               logic [9:0] dp);
    dsc_pkg::item_t w;
    w.req_type = kind; w.supply_voltage = v;
    w.step_position = sp; w.rail_position = rp; w.door_position = dp;
    return w;
  endfunction

  function automatic dsc_pkg::item_t rand_word(logic [1:0] kind);
    return make_word(kind, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
                     10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
  endfunction

  // actuator creeps toward its drive command by a random amount
  function automatic int drift(int pos, bit drive);
    int d;
    d = $urandom_range(0, 250);
    if (drive) return (pos + d > 1000) ? 1000 : pos + d;
    return (pos < d) ? 0 : pos - d;
  endfunction

  function automatic dsc_pkg::item_t next_word();
    int             r, vmin;
    dsc_pkg::item_t w;
    r    = $urandom_range(0, 99);
    vmin = (9 * int'(tracker.cfg.nominal_voltage) + 9) / 10;
    if (r < 3) begin
      w = rand_word(2'($urandom_range(0, 3)));
    end else if (r < 5) begin
      w = rand_word(REQ_SPARE);
    end else if (r < 8) begin
      w = rand_word(dsc_pkg::REQ_OPEN);
    end else if (r < 11) begin
      w = rand_word(dsc_pkg::REQ_CLOSE);
    end else if (tracker.open_req && door_pos > 950 && $urandom_range(0, 12) == 0) begin
      w = rand_word(dsc_pkg::REQ_CLOSE);
    end else if (!tracker.open_req && step_pos < 50 && rail_pos < 50 && door_pos < 50 &&
                 $urandom_range(0, 6) == 0) begin
      w = rand_word(dsc_pkg::REQ_OPEN);
    end else begin
      step_pos = drift(step_pos, tracker.step_cmd);
      rail_pos = drift(rail_pos, tracker.rail_cmd);
      door_pos = drift(door_pos, tracker.door_cmd);
      w = make_word(dsc_pkg::REQ_TICK, 8'($urandom_range(vmin, 255)), 10'(step_pos),
                    10'(rail_pos), 10'(door_pos));
      if (r < 14)  // brown-out, often right at the threshold
        w.supply_voltage = ($urandom_range(0, 1) == 1) ? 8'(vmin - 1)
                                                       : 8'($urandom_range(0, vmin - 1));
    end
    return w;
  endfunction

  task automatic send_word(dsc_pkg::item_t w);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, w.door_position, w.rail_position, w.step_position,
                      w.supply_voltage};
    s_axis_tuser  <= w.req_type;
    do @(posedge clk); while (!s_axis_tready);
    tracker.take_word(w);
  endtask

  // stop sending and wait until every owed word is out
  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (tracker.pending_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(int nominal, int steps, int warn, int blink);
    logic [15:0] vals[4];
    vals[dsc_pkg::REG_NOMINAL] = 16'(nominal);
    vals[dsc_pkg::REG_STEPS]   = 16'(steps);
    vals[dsc_pkg::REG_WARN]    = 16'(warn);
    vals[dsc_pkg::REG_BLINK]   = 16'(blink);
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      tracker.write_reg(2'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int n);
    repeat (n) send_word(next_word());
    finish_phase();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under the reset settings (nominal 110 -> threshold 99 V)
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd99, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd98, 10'd0, 10'd0, 10'd0));
    send_word(rand_word(REQ_SPARE));
    send_word(make_word(dsc_pkg::REQ_OPEN, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_OPEN, 8'hff, 10'h3ff, 10'h3ff, 10'h3ff));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd255, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd200, 10'd951, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd200, 10'd1000, 10'd951, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd200, 10'd1000, 10'd1000, 10'd951));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd200, 10'd1023, 10'd1023, 10'd1023));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd200, 10'd950, 10'd950, 10'd950));
    send_word(rand_word(REQ_SPARE));
    send_word(make_word(dsc_pkg::REQ_CLOSE, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd150, 10'd1000, 10'd1000, 10'd1000));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd150, 10'd1000, 10'd1000, 10'd50));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd150, 10'd50, 10'd50, 10'd49));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd150, 10'd49, 10'd49, 10'd49));
    send_word(make_word(dsc_pkg::REQ_OPEN, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd0, 10'd600, 10'd600, 10'd600));
    send_word(make_word(dsc_pkg::REQ_CLOSE, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd120, 10'd600, 10'd600, 10'd600));
    send_word(make_word(dsc_pkg::REQ_OPEN, 8'd0, 10'd0, 10'd0, 10'd0));
    send_word(make_word(dsc_pkg::REQ_TICK, 8'd120, 10'd600, 10'd600, 10'd600));
    finish_phase();

    // settings sweep: extremes first, then short timers so the warning runs out
    program_regs(1, 0, 0, 1);
    run_random(230);
    program_regs(255, 1, 16'hffff, 16'hffff);
    run_random(230);
    program_regs(110, 1, 3, 2);
    run_random(230);
    program_regs(200, 0, 16'hffff, 1);
    run_random(230);
    repeat (3) begin
      program_regs($urandom_range(1, 255), $urandom_range(0, 1),
                   $urandom_range(0, 24), $urandom_range(1, 8));
      run_random(230);
    end
    calm = 1;
    program_regs($urandom_range(1, 255), 1, $urandom_range(0, 12), $urandom_range(1, 4));
    run_random(230);

    repeat (6) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_outputs.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- door_sequence_controller_core.f -----
rtl/core/dsc_pkg.sv
rtl/core/dsc_timer.sv
rtl/core/dsc_seq.sv
rtl/core/door_sequence_controller_core.sv
test/tb_top.sv
